/* rtl/core/rtlpm_pkg.sv */
// Package with shared types, codes and helpers of the route table unit.
`timescale 1ns / 1ps
`default_nettype none

package rtlpm_pkg;

    localparam int ENTRIES_DEF = 32;
    localparam int TABLES_DEF  = 4;
    localparam int PREF_W      = 6;
    localparam logic [31:0] MASK_MSB = 32'h8000_0000;

    typedef enum logic [1:0] {
        REQ_ADD    = 2'd0,
        REQ_DEL    = 2'd1,
        REQ_LOOKUP = 2'd2,
        REQ_NONE   = 2'd3
    } t_req_code;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_NOT_FOUND = 2'd2,
        STAT_BAD_TABLE = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [2:0]  table_num;
        logic [31:0] dest_addr;
        logic [31:0] net_mask;
        logic [31:0] gateway_addr;
        logic [7:0]  iface_index;
        logic [31:0] route_metric;
        logic [7:0]  route_flags;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic        found;
        logic [31:0] out_dest;
        logic [31:0] out_mask;
        logic [31:0] out_gateway;
        logic [7:0]  out_if_idx;
        logic [31:0] out_metric;
        logic [7:0]  out_flags;
    } t_rsp;

    typedef struct packed {
        logic [31:0] dest;
        logic [31:0] mask;
        logic [31:0] gateway;
        logic [7:0]  iface;
        logic [31:0] metric;
        logic [7:0]  flags;
    } t_entry;

    // Number of ones above the most significant zero of the mask.
    function automatic logic [PREF_W-1:0] lead_ones(input logic [31:0] m);
        logic [PREF_W-1:0] n;
        n = PREF_W'(32);
        for (int i = 0; i < 32; i++) begin
            if ((m & (MASK_MSB >> (31 - i))) == 32'd0) begin
                n = PREF_W'(31 - i);
            end
        end
        return n;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/rtlpm_if.sv */
// Valid/ready channel interfaces for route requests and route results.
`timescale 1ns / 1ps
`default_nettype none

interface rtlpm_req_if;
    import rtlpm_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rtlpm_rsp_if;
    import rtlpm_pkg::*;
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/core/rtlpm_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module rtlpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

/* rtl/core/route_table_longest_prefix_unit.sv */
// Top level of the route table unit: add, delete and longest-prefix lookup.
//
//  channel  | dir | kind        | payload
//  ---------+-----+-------------+-------------------------------------------
//  i_req    | in  | valid/ready | req_type, table_num, route fields
//  o_rsp    | out | valid/ready | status, found, chosen route fields
//
// All routes sit in one RAM, one entry read per cycle. A lookup scans every
// entry of the addressed table; an add stops at a matching entry to replace
// it in place, and a delete also shifts the later entries down. Bad-table and
// unknown requests skip the scan.
// Reset clears fill counts and control state; the RAM itself is never cleared.
// A result waits in the output register; the next transaction is accepted
// meanwhile and finishes once that register is free.
`timescale 1ns / 1ps
`default_nettype none

module route_table_longest_prefix_unit #(
    parameter int ENTRIES_PER_TABLE = rtlpm_pkg::ENTRIES_DEF,
    parameter int TABLE_COUNT       = rtlpm_pkg::TABLES_DEF
) (
    input wire logic    i_clk,
    input wire logic    i_rst_n,
    rtlpm_req_if.sink   i_req,
    rtlpm_rsp_if.source o_rsp
);
    import rtlpm_pkg::*;

    localparam int DEPTH = ENTRIES_PER_TABLE * TABLE_COUNT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int TW    = (TABLE_COUNT > 1) ? $clog2(TABLE_COUNT) : 1;
    localparam int IW    = $clog2(ENTRIES_PER_TABLE + 1);
    localparam int EW    = $bits(t_entry);
    localparam logic [IW-1:0] ENTRY_MAX    = IW'(ENTRIES_PER_TABLE);
    localparam logic [AW-1:0] ENTRY_STRIDE = AW'(ENTRIES_PER_TABLE);

    t_state          r_state, n_state;
    t_req            r_req, n_req;
    logic [TW-1:0]   r_tbl, n_tbl;
    logic [AW-1:0]   r_base, n_base;
    logic [IW-1:0]   r_fill [TABLE_COUNT];
    logic [IW-1:0]   r_fill_cur, n_fill_cur;
    logic [IW-1:0]   r_rd_idx, n_rd_idx;
    logic            r_p1_valid, n_p1_valid;
    logic [IW-1:0]   r_p1_idx, n_p1_idx;
    logic            r_p2_valid, n_p2_valid;
    logic [PREF_W-1:0] r_p2_pref, n_p2_pref;
    t_entry          r_p2_entry, n_p2_entry;
    logic            r_hit, n_hit;
    logic [PREF_W-1:0] r_best_pref, n_best_pref;
    t_entry          r_best, n_best;
    t_status         r_status, n_status;
    logic            r_found, n_found;
    logic            r_out_valid, n_out_valid;
    t_rsp            r_out, n_out;

    logic            fill_we;
    logic [IW-1:0]   fill_val;
    logic            ram_we, ram_re;
    logic [AW-1:0]   ram_waddr, ram_raddr;
    logic [EW-1:0]   ram_wdata, ram_rdata;
    t_entry          p1_entry, req_entry;
    logic            p1_key_eq, tbl_ok, is_lookup;

    rtlpm_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign i_req.ready = (r_state == ST_IDLE);
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_tbl       = r_tbl;
        n_base      = r_base;
        n_fill_cur  = r_fill_cur;
        n_rd_idx    = r_rd_idx;
        n_p1_valid  = 1'b0;
        n_p1_idx    = r_p1_idx;
        n_hit       = r_hit;
        n_best_pref = r_best_pref;
        n_best      = r_best;
        n_status    = r_status;
        n_found     = r_found;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        fill_we     = 1'b0;
        fill_val    = r_fill_cur;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_waddr   = r_base + AW'(r_p1_idx);
        ram_raddr   = r_base + AW'(r_rd_idx);
        ram_wdata   = ram_rdata;

        p1_entry  = t_entry'(ram_rdata);
        p1_key_eq = (p1_entry.dest == r_req.dest_addr) && (p1_entry.mask == r_req.net_mask);
        is_lookup = (r_req.req_type == REQ_LOOKUP);
        tbl_ok    = ({1'b0, i_req.data.table_num} < 4'(TABLE_COUNT));

        req_entry.dest    = r_req.dest_addr;
        req_entry.mask    = r_req.net_mask;
        req_entry.gateway = r_req.gateway_addr;
        req_entry.iface   = r_req.iface_index;
        req_entry.metric  = r_req.route_metric;
        req_entry.flags   = r_req.route_flags;

        // Lookup stage two: up flag, masked match and prefix length.
        n_p2_valid = r_p1_valid && is_lookup && p1_entry.flags[0]
                     && ((r_req.dest_addr & p1_entry.mask) == (p1_entry.dest & p1_entry.mask));
        n_p2_pref  = lead_ones(p1_entry.mask);
        n_p2_entry = p1_entry;

        // Lookup stage three: longer prefix, then lower metric; else the earlier.
        if (r_p2_valid && (!r_hit || (r_p2_pref > r_best_pref) ||
            ((r_p2_pref == r_best_pref) && (r_p2_entry.metric < r_best.metric)))) begin
            n_hit       = 1'b1;
            n_best_pref = r_p2_pref;
            n_best      = r_p2_entry;
        end

        if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_req.valid) begin
                    n_req      = i_req.data;
                    n_tbl      = i_req.data.table_num[TW-1:0];
                    n_base     = AW'(i_req.data.table_num[TW-1:0]) * ENTRY_STRIDE;
                    n_fill_cur = r_fill[i_req.data.table_num[TW-1:0]];
                    n_rd_idx   = '0;
                    n_hit      = 1'b0;
                    n_found    = 1'b0;
                    n_status   = STAT_OK;
                    if (i_req.data.req_type == REQ_NONE) begin
                        n_state = ST_DONE;
                    end else if (!tbl_ok) begin
                        n_status = STAT_BAD_TABLE;
                        n_state  = ST_DONE;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (r_p1_valid && !is_lookup && p1_key_eq) begin
                    if (r_req.req_type == REQ_ADD) begin
                        ram_we    = 1'b1;
                        ram_wdata = req_entry;
                        n_state   = ST_DONE;
                    end else begin
                        n_rd_idx = r_p1_idx + IW'(1);
                        n_state  = ST_SHIFT;
                    end
                end else if (r_rd_idx < r_fill_cur) begin
                    ram_re     = 1'b1;
                    n_p1_valid = 1'b1;
                    n_p1_idx   = r_rd_idx;
                    n_rd_idx   = r_rd_idx + IW'(1);
                end else if (!r_p1_valid && !r_p2_valid) begin
                    case (r_req.req_type)
                        REQ_ADD: begin
                            if (r_fill_cur == ENTRY_MAX) begin
                                n_status = STAT_FULL;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = r_base + AW'(r_fill_cur);
                                ram_wdata = req_entry;
                                fill_we   = 1'b1;
                                fill_val  = r_fill_cur + IW'(1);
                            end
                        end
                        REQ_DEL: begin
                            n_status = STAT_NOT_FOUND;
                        end
                        default: begin
                            if (r_hit) begin
                                n_found = 1'b1;
                            end else begin
                                n_status = STAT_NOT_FOUND;
                            end
                        end
                    endcase
                    n_state = ST_DONE;
                end
            end
            ST_SHIFT: begin
                // Each entry after the removed one moves down by one place.
                if (r_p1_valid) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_base + AW'(r_p1_idx - IW'(1));
                end
                if (r_rd_idx < r_fill_cur) begin
                    ram_re     = 1'b1;
                    n_p1_valid = 1'b1;
                    n_p1_idx   = r_rd_idx;
                    n_rd_idx   = r_rd_idx + IW'(1);
                end else if (!r_p1_valid) begin
                    fill_we  = 1'b1;
                    fill_val = r_fill_cur - IW'(1);
                    n_state  = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid       = 1'b1;
                    n_out.status      = r_status;
                    n_out.found       = r_found;
                    n_out.out_dest    = r_found ? r_best.dest    : 32'd0;
                    n_out.out_mask    = r_found ? r_best.mask    : 32'd0;
                    n_out.out_gateway = r_found ? r_best.gateway : 32'd0;
                    n_out.out_if_idx  = r_found ? r_best.iface   : 8'd0;
                    n_out.out_metric  = r_found ? r_best.metric  : 32'd0;
                    n_out.out_flags   = r_found ? r_best.flags   : 8'd0;
                    n_state           = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_p1_valid  <= 1'b0;
            r_p2_valid  <= 1'b0;
            r_hit       <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
            for (int t = 0; t < TABLE_COUNT; t++) begin
                r_fill[t] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_p1_valid  <= n_p1_valid;
            r_p2_valid  <= n_p2_valid;
            r_hit       <= n_hit;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
            if (fill_we) begin
                r_fill[r_tbl] <= fill_val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_req       <= n_req;
        r_tbl       <= n_tbl;
        r_base      <= n_base;
        r_fill_cur  <= n_fill_cur;
        r_rd_idx    <= n_rd_idx;
        r_p1_idx    <= n_p1_idx;
        r_p2_pref   <= n_p2_pref;
        r_p2_entry  <= n_p2_entry;
        r_best_pref <= n_best_pref;
        r_best      <= n_best;
        r_status    <= n_status;
        r_out       <= n_out;
    end

`ifndef SYNTH
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fill_we |-> (fill_val <= ENTRY_MAX))
        else $error("table fill count exceeds table size");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> (r_state != ST_IDLE))
        else $error("accepted transaction did not start processing");

    a_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> ((r_state == ST_SCAN) || (r_state == ST_SHIFT)))
        else $error("route memory written outside scan or shift");

    a_shift_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("route memory read and write hit the same entry");

    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.data.found) |-> (o_rsp.data.status == STAT_OK))
        else $error("found result carries an error status");
`endif

endmodule

`default_nettype wire

/* test/tb_route_table_longest_prefix_unit.sv */
// Self-checking testbench for the route table unit: add, delete and longest-prefix lookup.
`timescale 1ns / 1ps

module tb_route_table_longest_prefix_unit;
    import rtlpm_pkg::*;

    localparam int TABLES      = TABLES_DEF;
    localparam int ENTRIES     = ENTRIES_DEF;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 150;

    logic i_clk = 1'b0;
    logic i_rst_n;

    rtlpm_req_if req_ch ();
    rtlpm_rsp_if rsp_ch ();

    route_table_longest_prefix_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    always #5 i_clk = ~i_clk;

    // Shadow copy of the route tables, kept in insertion order.
    t_entry route_store [TABLES][ENTRIES];
    int     route_count [TABLES];

    t_rsp awaited_results [$];
    int   error_count  = 0;
    int   idle_cycles  = 0;
    bit   req_idle_on  = 1'b0;
    bit   rsp_idle_on  = 1'b0;
    int   rsp_hold_len = 0;

    function automatic logic [31:0] prefix_mask(int len);
        return (len == 0) ? 32'd0 : (~32'd0 << (32 - len));
    endfunction

    function automatic int prefix_len(logic [31:0] m);
        int n;
        n = 0;
        while (n < 32 && m[31 - n]) begin
            n++;
        end
        return n;
    endfunction

    function automatic int route_index(int tbl, logic [31:0] dest, logic [31:0] mask);
        for (int i = 0; i < route_count[tbl]; i++) begin
            if (route_store[tbl][i].dest == dest && route_store[tbl][i].mask == mask) begin
                return i;
            end
        end
        return -1;
    endfunction

    // Applies one request to the shadow tables and returns the result it must produce.
    function automatic t_rsp route_table_apply(t_req r);
        t_rsp   res;
        t_entry e;
        int     tbl;
        int     idx;
        int     best;
        int     best_len;
        int     len;
        bit     hit;
        res = '0;
        tbl = int'(r.table_num);
        if (r.req_type == REQ_NONE) begin
            return res;
        end
        if (tbl >= TABLES) begin
            res.status = STAT_BAD_TABLE;
            return res;
        end
        case (r.req_type)
            REQ_ADD: begin
                idx = route_index(tbl, r.dest_addr, r.net_mask);
                if (idx < 0 && route_count[tbl] >= ENTRIES) begin
                    res.status = STAT_FULL;
                end else begin
                    if (idx < 0) begin
                        idx = route_count[tbl];
                        route_count[tbl]++;
                        route_store[tbl][idx].dest = r.dest_addr;
                        route_store[tbl][idx].mask = r.net_mask;
                    end
                    route_store[tbl][idx].gateway = r.gateway_addr;
                    route_store[tbl][idx].iface   = r.iface_index;
                    route_store[tbl][idx].metric  = r.route_metric;
                    route_store[tbl][idx].flags   = r.route_flags;
                end
            end
            REQ_DEL: begin
                idx = route_index(tbl, r.dest_addr, r.net_mask);
                if (idx < 0) begin
                    res.status = STAT_NOT_FOUND;
                end else begin
                    for (int k = idx; k + 1 < route_count[tbl]; k++) begin
                        route_store[tbl][k] = route_store[tbl][k + 1];
                    end
                    route_count[tbl]--;
                end
            end
            default: begin
                hit      = 1'b0;
                best     = 0;
                best_len = 0;
                for (int i = 0; i < route_count[tbl]; i++) begin
                    e = route_store[tbl][i];
                    if (e.flags[0] && ((r.dest_addr & e.mask) == (e.dest & e.mask))) begin
                        len = prefix_len(e.mask);
                        if (!hit || len > best_len ||
                            (len == best_len && e.metric < route_store[tbl][best].metric)) begin
                            hit      = 1'b1;
                            best     = i;
                            best_len = len;
                        end
                    end
                end
                if (!hit) begin
                    res.status = STAT_NOT_FOUND;
                end else begin
                    e               = route_store[tbl][best];
                    res.found       = 1'b1;
                    res.out_dest    = e.dest;
                    res.out_mask    = e.mask;
                    res.out_gateway = e.gateway;
                    res.out_if_idx  = e.iface;
                    res.out_metric  = e.metric;
                    res.out_flags   = e.flags;
                end
            end
        endcase
        return res;
    endfunction

    // Builds a request with random content. Delete and lookup requests mostly, and adds
    // less often, reuse a stored route so that replaces, deletes and lookup hits are common.
    function automatic t_req make_route_req(t_req_code op, int tbl);
        t_req   r;
        t_entry e;
        int     len;
        bit     reuse;
        r              = '0;
        r.req_type     = op;
        r.table_num    = 3'(tbl);
        r.gateway_addr = $urandom;
        r.iface_index  = 8'($urandom);
        r.route_flags  = 8'($urandom);
        if ($urandom_range(0, 4) != 0) begin
            r.route_flags[0] = 1'b1;
        end
        r.route_metric = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 3);
        len = ($urandom_range(0, 1) == 1) ? 8 * $urandom_range(0, 4) : $urandom_range(0, 32);
        r.net_mask  = ($urandom_range(0, 5) == 0) ? $urandom : prefix_mask(len);
        r.dest_addr = $urandom;
        reuse = (tbl < TABLES) && (route_count[tbl] > 0) &&
                ($urandom_range(0, 9) < ((op == REQ_ADD) ? 4 : 7));
        if (reuse) begin
            e = route_store[tbl][$urandom_range(0, route_count[tbl] - 1)];
            if (op == REQ_LOOKUP) begin
                r.dest_addr = (e.dest & e.mask) | ($urandom & ~e.mask);
            end else begin
                r.dest_addr = e.dest;
                r.net_mask  = e.mask;
            end
        end
        return r;
    endfunction

    // Offers one request until the unit takes it, then records the expected result.
    task automatic send_req(input t_req r);
        if (req_idle_on && $urandom_range(0, 3) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        req_ch.data  <= r;
        req_ch.valid <= 1'b1;
        @(posedge i_clk);
        while (req_ch.ready !== 1'b1) begin
            @(posedge i_clk);
        end
        awaited_results.push_back(route_table_apply(r));
    endtask

    task automatic send_route(t_req_code op, int tbl, logic [31:0] dest, logic [31:0] mask,
                              logic [31:0] gw, logic [7:0] iface, logic [31:0] metric,
                              logic [7:0] flags);
        t_req r;
        r.req_type     = op;
        r.table_num    = 3'(tbl);
        r.dest_addr    = dest;
        r.net_mask     = mask;
        r.gateway_addr = gw;
        r.iface_index  = iface;
        r.route_metric = metric;
        r.route_flags  = flags;
        send_req(r);
    endtask

    task automatic test_rejects();
        send_route(REQ_ADD, 4, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF,
                   32'hFFFF_FFFF, 8'hFF);
        send_route(REQ_DEL, 5, 32'h0A00_0000, prefix_mask(8), 32'd0, 8'd0, 32'd0, 8'd0);
        send_route(REQ_LOOKUP, 7, 32'h0A01_0203, 32'd0, 32'd0, 8'd0, 32'd0, 8'd0);
        send_route(REQ_NONE, 0, 32'h0A00_0000, prefix_mask(8), 32'd1, 8'd1, 32'd1, 8'd1);
        send_route(REQ_NONE, 6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 8'd0, 32'd0, 8'd1);
    endtask

    task automatic test_prefix_selection();
        // Lookup on an empty table misses.
        send_route(REQ_LOOKUP, 1, 32'd0, 32'd0, 32'd0, 8'd0, 32'd0, 8'd0);
        // Default route with gateway, interface and metric at their maximum; only the up flag is set.
        send_route(REQ_ADD, 1, 32'd0, 32'd0, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF, 8'h01);
        send_route(REQ_LOOKUP, 1, 32'hFFFF_FFFF, 32'd0, 32'd0, 8'd0, 32'd0, 8'd0);
        send_route(REQ_ADD, 1, 32'h0A00_0000, prefix_mask(8), 32'd1, 8'd1, 32'd10, 8'hFF);
        // The /16 is down, so the /8 must win.
        send_route(REQ_ADD, 1, 32'h0A01_0000, prefix_mask(16), 32'd2, 8'd2, 32'd5, 8'hFE);
        send_route(REQ_LOOKUP, 1, 32'h0A01_0203, 32'd0, 32'd0, 8'd0, 32'd0, 8'd0);
        // Replacing the /16 with the up flag set makes it the longest match.
        send_route(REQ_ADD, 1, 32'h0A01_0000, prefix_mask(16), 32'd3, 8'd3, 32'd5, 8'h01);
        send_route(REQ_LOOKUP, 1, 32'h0A01_0203, 32'd0, 32'd0, 8'd0, 32'd0, 8'd0);
        // A non-contiguous mask counts only its leading ones, but matches on all bits.
        send_route(REQ_ADD, 1, 32'h0A00_FF00, 32'hFF00_FF00, 32'd4, 8'd4, 32'd3, 8'h01);
        send_route(REQ_LOOKUP, 1, 32'h0A02_FF05, 32'd0, 32'd0, 8'd0, 32'd0, 8'd0);
        // Same prefix and metric: the earlier entry keeps the win.
        send_route(REQ_ADD, 1, 32'h0A7F_0000, prefix_mask(8), 32'd5, 8'd5, 32'd3, 8'h01);
        send_route(REQ_LOOKUP, 1, 32'h0A02_FF05, 32'd0, 32'd0, 8'd0, 32'd0, 8'd0);
        send_route(REQ_ADD, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 8'd0, 32'd0, 8'h01);
        send_route(REQ_LOOKUP, 1, 32'hFFFF_FFFF, 32'd0, 32'd0, 8'd0, 32'd0, 8'd0);
        send_route(REQ_DEL, 1, 32'h0A01_0000, prefix_mask(8), 32'd0, 8'd0, 32'd0, 8'd0);
        send_route(REQ_DEL, 1, 32'h0A00_FF00, 32'hFF00_FF00, 32'd0, 8'd0, 32'd0, 8'd0);
        send_route(REQ_LOOKUP, 1, 32'h0A02_FF05, 32'd0, 32'd0, 8'd0, 32'd0, 8'd0);
        send_route(REQ_DEL, 1, 32'd0, 32'd0, 32'd0, 8'd0, 32'd0, 8'd0);
        send_route(REQ_LOOKUP, 1, 32'h0B00_0000, 32'd0, 32'd0, 8'd0, 32'd0, 8'd0);
    endtask

    task automatic test_random_traffic(int count, bit with_idle);
        int   roll;
        int   tbl;
        t_req r;
        req_idle_on = with_idle;
        rsp_idle_on = with_idle;
        repeat (count) begin
            roll = $urandom_range(0, 99);
            tbl  = ($urandom_range(0, 19) == 0) ? $urandom_range(TABLES, 7)
                                                : $urandom_range(0, TABLES - 1);
            if (roll < 3) begin
                r = make_route_req(REQ_NONE, $urandom_range(0, 7));
            end else if (roll < 38) begin
                r = make_route_req(REQ_ADD, tbl);
            end else if (roll < 65) begin
                r = make_route_req(REQ_DEL, tbl);
            end else begin
                r = make_route_req(REQ_LOOKUP, tbl);
            end
            send_req(r);
        end
    endtask

    // The receiver holds off while requests keep coming, so the unit must stall
    // its input; then the sender waits until every result is back.
    task automatic test_backpressure();
        req_idle_on  = 1'b0;
        rsp_idle_on  = 1'b0;
        rsp_hold_len = HOLD_CYCLES;
        for (int i = 0; i < 20; i++) begin
            send_req(make_route_req((i % 2 == 0) ? REQ_ADD : REQ_LOOKUP, 2));
        end
        req_ch.valid <= 1'b0;
        while (awaited_results.size() != 0) begin
            @(posedge i_clk);
        end
        for (int i = 0; i < 4; i++) begin
            send_req(make_route_req(REQ_LOOKUP, 2));
        end
    endtask

    task automatic test_table_capacity();
        t_req   r;
        t_entry e;
        int     guard;
        req_idle_on = 1'b1;
        rsp_idle_on = 1'b1;
        guard = 0;
        while (route_count[3] < ENTRIES && guard < 200) begin
            r = make_route_req(REQ_ADD, 3);
            send_req(r);
            guard++;
        end
        // A new route no longer fits.
        do begin
            r = make_route_req(REQ_ADD, 3);
            r.dest_addr = $urandom;
        end while (route_index(3, r.dest_addr, r.net_mask) >= 0);
        send_req(r);
        // A matching route is still replaced in a full table.
        e = route_store[3][$urandom_range(0, ENTRIES - 1)];
        r = make_route_req(REQ_ADD, 3);
        r.dest_addr = e.dest;
        r.net_mask  = e.mask;
        send_req(r);
        repeat (6) send_req(make_route_req(REQ_LOOKUP, 3));
        repeat (6) send_req(make_route_req(REQ_DEL, 3));
        repeat (4) send_req(make_route_req(REQ_LOOKUP, 3));
    endtask

    // Receiver side: bursts of stall, one long hold-off on request, or always ready.
    initial begin : rsp_drain
        forever begin
            if (rsp_hold_len > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (rsp_hold_len) @(posedge i_clk);
                rsp_hold_len = 0;
            end else if (rsp_idle_on && $urandom_range(0, 5) == 0) begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end else begin
                rsp_ch.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
            error_count++;
        end
    endfunction

    always @(posedge i_clk) begin : rsp_check
        t_rsp exp_rsp;
        t_rsp got;
        if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            got = rsp_ch.data;
            if (awaited_results.size() == 0) begin
                $error("unexpected result transaction: status %0d", got.status);
                error_count++;
            end else begin
                exp_rsp = awaited_results.pop_front();
                check_field("status", 32'(exp_rsp.status), 32'(got.status));
                check_field("found", 32'(exp_rsp.found), 32'(got.found));
                check_field("out_dest", exp_rsp.out_dest, got.out_dest);
                check_field("out_mask", exp_rsp.out_mask, got.out_mask);
                check_field("out_gateway", exp_rsp.out_gateway, got.out_gateway);
                check_field("out_if_idx", 32'(exp_rsp.out_if_idx), 32'(got.out_if_idx));
                check_field("out_metric", exp_rsp.out_metric, got.out_metric);
                check_field("out_flags", 32'(exp_rsp.out_flags), 32'(got.out_flags));
            end
        end
    end

    // Ends the run if no transaction moves on either channel for too long.
    always @(posedge i_clk) begin
        if (i_rst_n !== 1'b1 || (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
            (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("tb_route_table_longest_prefix_unit: done, errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : main_seq
        for (int t = 0; t < TABLES; t++) begin
            route_count[t] = 0;
        end
        i_rst_n      = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_rejects();
        test_prefix_selection();
        test_random_traffic(200, 1'b1);
        test_backpressure();
        test_table_capacity();
        test_random_traffic(250, 1'b0);

        req_ch.valid <= 1'b0;
        while (awaited_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (60) @(posedge i_clk);
        if (error_count == 0) begin
            $display("tb_route_table_longest_prefix_unit: done, clean");
        end else begin
            $display("tb_route_table_longest_prefix_unit: done, errors");
        end
        $finish;
    end

endmodule
